// File: rtl/core/ir_line_follow_controller_macros.svh
// ----------------------------------------------------------------------------
// Line-follow controller assertion macros
// Property shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef IR_LINE_FOLLOW_CONTROLLER_MACROS_SVH
`define IR_LINE_FOLLOW_CONTROLLER_MACROS_SVH

// same-cycle implication
`define LFC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LFC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/lfc_pkg.sv
// ----------------------------------------------------------------------------
// Line-follow controller package
// Codes and fixed constants shared by the controller files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfc_pkg;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_SEARCH = 3'd1;
    localparam logic [2:0] PH_PAUSE  = 3'd2;
    localparam logic [2:0] PH_PIVOT  = 3'd3;
    localparam logic [2:0] PH_ALIGN  = 3'd4;
    localparam logic [2:0] PH_FOLLOW = 3'd5;
    localparam logic [2:0] PH_EXIT   = 3'd6;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BUSY    = 3'd1;
    localparam logic [2:0] ST_RUNNING = 3'd2;
    localparam logic [2:0] ST_NEED_W  = 3'd3;
    localparam logic [2:0] ST_NEED_B  = 3'd4;
    localparam logic [2:0] ST_NOT_RUN = 3'd5;

    localparam logic [2:0] ACT_SERVICE = 3'd0;
    localparam logic [2:0] ACT_CAL_W   = 3'd1;
    localparam logic [2:0] ACT_CAL_B   = 3'd2;
    localparam logic [2:0] ACT_BEGIN   = 3'd3;
    localparam logic [2:0] ACT_DONE    = 3'd4;

    localparam logic [1:0] MODE_STOP  = 2'd0;
    localparam logic [1:0] MODE_FWD   = 2'd1;
    localparam logic [1:0] MODE_PIVOT = 2'd2;

    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    localparam logic [2:0] REG_LMIN   = 3'd0;
    localparam logic [2:0] REG_RMIN   = 3'd1;
    localparam logic [2:0] REG_GAIN   = 3'd2;
    localparam logic [2:0] REG_FBASE  = 3'd3;
    localparam logic [2:0] REG_ABASE  = 3'd4;
    localparam logic [2:0] REG_STO    = 3'd5;
    localparam logic [2:0] REG_EXIT   = 3'd6;
    localparam logic [2:0] REG_TOL    = 3'd7;

    localparam logic [14:0] MAX_DRIVE     = 15'd32000;
    localparam logic [14:0] SEARCH_LEFT   = 15'd21000;
    localparam logic [14:0] SEARCH_RIGHT  = 15'd11000;
    localparam logic [14:0] PIVOT_DRIVE   = 15'd16000;
    localparam logic [14:0] DEFICIT_DROP  = 15'd4000;
    localparam int          DEFICIT_GAIN  = 80;
    localparam int          DEFICIT_LIMIT = 30;
    localparam int          TARGET_OFFSET = 50;
    localparam int          MARGIN_MIN    = 10;
    localparam int          MARGIN_MAX    = 20;
    localparam int          LOST_BIAS     = 7000;
    localparam logic [15:0] PAUSE_TICKS   = 16'd2;
    localparam logic [15:0] PIVOT_TICKS   = 16'd5;
    localparam logic [15:0] STABLE_TICKS  = 16'd5;

endpackage

// File: rtl/core/lfc_div.sv
// ----------------------------------------------------------------------------
// Line-follow controller serial divider
// Restoring unsigned divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfc_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_den, n_den;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_quo[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_den   = r_den;
        n_rem   = r_rem;
        if (i_start) begin
            n_cnt = CNT_W'(NUM_W);
            n_quo = i_num;
            n_den = i_den;
            n_rem = '0;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (rem_sh >= {1'b0, r_den}) begin
                n_rem = rem_sub[DEN_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[DEN_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_quo <= n_quo;
        r_den <= n_den;
        r_rem <= n_rem;
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quo;

endmodule

// File: rtl/core/ir_line_follow_controller.sv
// ----------------------------------------------------------------------------
// Two-sensor infrared line-follow controller
// A word taken in idle passes a load state that starts the shared serial
// divider, which forms the steering term gain*(right-left)/(right+left); a
// divide state that waits until the divider is no longer busy; and a finish
// state that updates the phase machine and registers the result. The finish
// state waits while an earlier result word is still held by i_out_ready.
// The next word is taken once the sequencer is back in idle, so a new word
// is not accepted while the last one is still in work.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ir_line_follow_controller #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [2:0]             i_action,
    input  logic [SAMPLE_BITS-1:0] i_left_sample,
    input  logic [SAMPLE_BITS-1:0] i_right_sample,
    input  logic                   i_tick,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [2:0]             o_status,
    output logic [2:0]             o_phase,
    output logic [1:0]             o_drive_mode,
    output logic [14:0]            o_left_drive,
    output logic [14:0]            o_right_drive,
    output logic                   o_emitter_on,
    output logic                   o_calibrated,
    output logic [11:0]            o_echo_left,
    output logic [11:0]            o_echo_right,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int SB    = SAMPLE_BITS;
    localparam int NUM_W = SB + 16;
    localparam int DEN_W = SB + 1;
    localparam int DW    = SB + 20;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_seq;

    function automatic logic [14:0] cmd_speed(input logic [14:0] v, input logic [14:0] mn);
        logic [14:0] c;
        c = (v > lfc_pkg::MAX_DRIVE) ? lfc_pkg::MAX_DRIVE : v;
        if (c != '0 && c < mn) c = mn;
        return c;
    endfunction

    function automatic logic [SB-1:0] pick_margin(input logic [SB-1:0] b,
                                                 input logic [SB-1:0] w,
                                                 input logic wv);
        logic [SB-1:0] d;
        logic [SB-1:0] m;
        d = b - w;
        m = SB'(lfc_pkg::MARGIN_MIN);
        if (wv && b > w) begin
            if (d < SB'(lfc_pkg::MARGIN_MIN)) begin
                m = (d > SB'(2)) ? d - 1'b1 : SB'(1);
            end else if (d > SB'(lfc_pkg::MARGIN_MAX)) begin
                m = SB'(lfc_pkg::MARGIN_MAX);
            end
        end
        return m;
    endfunction

    function automatic logic [SB-1:0] pick_target(input logic [SB-1:0] b);
        logic [SB-1:0] frac;
        logic [SB-1:0] off;
        frac = b >> 2;
        if (frac == '0) frac = SB'(1);
        off = SB'(lfc_pkg::TARGET_OFFSET);
        if (off > frac) off = frac;
        if (off >= b) off = (b > SB'(1)) ? b - 1'b1 : '0;
        return (b == '0) ? '0 : b - off;
    endfunction

    // configuration
    logic [14:0] r_lmin, r_rmin, r_fbase, r_abase;
    logic [15:0] r_gain, r_sto, r_exit;
    logic [11:0] r_tol;

    // sequencer and captured word
    t_seq          r_seq, n_seq;
    logic [2:0]    r_act;
    logic [SB-1:0] r_l, r_r;
    logic          r_tick;

    // controller state
    logic [2:0]    r_phase, n_phase;
    logic [15:0]   r_pe, n_pe;
    logic [15:0]   r_ac, n_ac;
    logic [1:0]    r_side, n_side;
    logic [SB-1:0] r_wl [2];
    logic [SB-1:0] r_bl [2];
    logic [SB-1:0] r_thr [2];
    logic [SB-1:0] r_at [2];
    logic [SB-1:0] n_wl [2];
    logic [SB-1:0] n_bl [2];
    logic [SB-1:0] n_thr [2];
    logic [SB-1:0] n_at [2];
    logic          r_wv, n_wv, r_bv, n_bv, r_emit, n_emit;
    logic [1:0]    r_mode, n_mode;
    logic [14:0]   r_ld, n_ld, r_rd, n_rd;

    // result register
    logic          r_ov;
    logic [2:0]    r_o_status, n_status;
    logic [11:0]   r_o_el, r_o_er, n_el, n_er;

    // datapath
    logic             div_start, div_busy, fin_go;
    logic [NUM_W-1:0] div_num, div_quot;
    logic [DEN_W-1:0] div_den;
    logic [SB-1:0]    err_mag;
    logic             err_neg;

    logic [15:0]   pe1;
    logic          ll, rl;
    logic [SB-1:0] tl, tr, dl, dr, adiff;
    logic          big;
    logic [14:0]   base_in, base2, maxmin;
    logic signed [DW-1:0] qs, defterm, biasv, delta, lp, rp;
    logic [14:0]   bal_l, bal_r;
    logic [15:0]   ac_n;
    logic          cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lmin  <= 15'd8000;
            r_rmin  <= 15'd8000;
            r_gain  <= 16'd14000;
            r_fbase <= 15'd15000;
            r_abase <= 15'd13000;
            r_sto   <= 16'd150;
            r_exit  <= 16'd15;
            r_tol   <= 12'd25;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                lfc_pkg::REG_LMIN:  r_lmin  <= pwdata[14:0];
                lfc_pkg::REG_RMIN:  r_rmin  <= pwdata[14:0];
                lfc_pkg::REG_GAIN:  r_gain  <= pwdata[15:0];
                lfc_pkg::REG_FBASE: r_fbase <= pwdata[14:0];
                lfc_pkg::REG_ABASE: r_abase <= pwdata[14:0];
                lfc_pkg::REG_STO:   r_sto   <= pwdata[15:0];
                lfc_pkg::REG_EXIT:  r_exit  <= pwdata[15:0];
                lfc_pkg::REG_TOL:   r_tol   <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            lfc_pkg::REG_LMIN:  prdata = {17'd0, r_lmin};
            lfc_pkg::REG_RMIN:  prdata = {17'd0, r_rmin};
            lfc_pkg::REG_GAIN:  prdata = {16'd0, r_gain};
            lfc_pkg::REG_FBASE: prdata = {17'd0, r_fbase};
            lfc_pkg::REG_ABASE: prdata = {17'd0, r_abase};
            lfc_pkg::REG_STO:   prdata = {16'd0, r_sto};
            lfc_pkg::REG_EXIT:  prdata = {16'd0, r_exit};
            lfc_pkg::REG_TOL:   prdata = {20'd0, r_tol};
            default:            prdata = '0;
        endcase
    end

    // steering product feeds the divider load register
    assign err_neg   = (r_r < r_l);
    assign err_mag   = err_neg ? r_l - r_r : r_r - r_l;
    assign div_num   = NUM_W'(err_mag) * NUM_W'(r_gain);
    assign div_den   = (r_l == '0 && r_r == '0) ? DEN_W'(1) : DEN_W'(r_l) + DEN_W'(r_r);
    assign div_start = (r_seq == S_LOAD);

    lfc_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    assign fin_go = (r_seq == S_FIN) && (!r_ov || i_out_ready);

    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            S_IDLE:  if (i_in_valid) n_seq = S_LOAD;
            S_LOAD:  n_seq = S_DIV;
            S_DIV:   if (!div_busy) n_seq = S_FIN;
            S_FIN:   if (fin_go) n_seq = S_IDLE;
            default: n_seq = S_IDLE;
        endcase
    end

    // balanced drive
    always_comb begin
        pe1     = (r_tick && r_pe != 16'hFFFF) ? r_pe + 1'b1 : r_pe;
        ll      = r_bv && (r_l >= r_thr[0]);
        rl      = r_bv && (r_r >= r_thr[1]);
        tl      = (r_at[0] != '0) ? r_at[0] : r_bl[0];
        tr      = (r_at[1] != '0) ? r_at[1] : r_bl[1];
        dl      = (tl != '0 && r_l < tl) ? tl - r_l : '0;
        dr      = (tr != '0 && r_r < tr) ? tr - r_r : '0;
        big     = (dl > SB'(lfc_pkg::DEFICIT_LIMIT)) || (dr > SB'(lfc_pkg::DEFICIT_LIMIT));
        base_in = (r_phase == lfc_pkg::PH_ALIGN) ? r_abase : r_fbase;
        maxmin  = (r_lmin > r_rmin) ? r_lmin : r_rmin;
        base2   = base_in;
        if (big) begin
            base2 = (base_in > lfc_pkg::DEFICIT_DROP) ? base_in - lfc_pkg::DEFICIT_DROP : maxmin;
        end
        qs = $signed({{(DW-NUM_W){1'b0}}, div_quot});
        if (err_neg) qs = -qs;
        defterm = ($signed({{(DW-SB){1'b0}}, dr}) - $signed({{(DW-SB){1'b0}}, dl}))
                  * DW'(lfc_pkg::DEFICIT_GAIN);
        biasv = '0;
        if (r_phase == lfc_pkg::PH_FOLLOW && !ll && !rl) begin
            if (r_side == lfc_pkg::SIDE_LEFT) biasv = -DW'(lfc_pkg::LOST_BIAS);
            else if (r_side == lfc_pkg::SIDE_RIGHT) biasv = DW'(lfc_pkg::LOST_BIAS);
        end
        delta = qs + defterm + biasv;
        lp    = $signed({{(DW-15){1'b0}}, base2}) - delta;
        rp    = $signed({{(DW-15){1'b0}}, base2}) + delta;
        if (lp < $signed({{(DW-15){1'b0}}, r_lmin})) lp = $signed({{(DW-15){1'b0}}, r_lmin});
        if (rp < $signed({{(DW-15){1'b0}}, r_rmin})) rp = $signed({{(DW-15){1'b0}}, r_rmin});
        if (lp > $signed({{(DW-15){1'b0}}, lfc_pkg::MAX_DRIVE}))
            lp = $signed({{(DW-15){1'b0}}, lfc_pkg::MAX_DRIVE});
        if (rp > $signed({{(DW-15){1'b0}}, lfc_pkg::MAX_DRIVE}))
            rp = $signed({{(DW-15){1'b0}}, lfc_pkg::MAX_DRIVE});
        bal_l = lp[14:0];
        bal_r = rp[14:0];
        adiff = err_mag;
    end

    // phase machine update
    always_comb begin
        n_phase  = r_phase;
        n_pe     = pe1;
        n_ac     = r_ac;
        n_side   = r_side;
        n_wl     = r_wl;
        n_bl     = r_bl;
        n_thr    = r_thr;
        n_at     = r_at;
        n_wv     = r_wv;
        n_bv     = r_bv;
        n_emit   = r_emit;
        n_mode   = r_mode;
        n_ld     = r_ld;
        n_rd     = r_rd;
        n_status = lfc_pkg::ST_OK;
        n_el     = '0;
        n_er     = '0;
        ac_n     = r_ac;
        case (r_act)
            lfc_pkg::ACT_SERVICE: begin
                if (r_phase != lfc_pkg::PH_IDLE) n_emit = 1'b1;
                case (r_phase)
                    lfc_pkg::PH_IDLE: ;
                    lfc_pkg::PH_SEARCH: begin
                        if (ll || rl) begin
                            n_side  = ll ? lfc_pkg::SIDE_LEFT : lfc_pkg::SIDE_RIGHT;
                            n_phase = lfc_pkg::PH_PAUSE;
                            n_pe    = '0;
                            n_mode  = lfc_pkg::MODE_STOP;
                            n_ld    = '0;
                            n_rd    = '0;
                        end else if (pe1 > r_sto) begin
                            n_phase = lfc_pkg::PH_IDLE;
                            n_pe    = '0;
                            n_ac    = '0;
                            n_side  = lfc_pkg::SIDE_NONE;
                            n_mode  = lfc_pkg::MODE_STOP;
                            n_ld    = '0;
                            n_rd    = '0;
                        end
                    end
                    lfc_pkg::PH_PAUSE: begin
                        n_mode = lfc_pkg::MODE_STOP;
                        n_ld   = '0;
                        n_rd   = '0;
                        if (pe1 >= lfc_pkg::PAUSE_TICKS) begin
                            n_phase = lfc_pkg::PH_PIVOT;
                            n_pe    = '0;
                            n_mode  = lfc_pkg::MODE_PIVOT;
                            n_ld    = lfc_pkg::PIVOT_DRIVE;
                            n_rd    = lfc_pkg::PIVOT_DRIVE;
                        end
                    end
                    lfc_pkg::PH_PIVOT: begin
                        if (pe1 >= lfc_pkg::PIVOT_TICKS) begin
                            n_phase = lfc_pkg::PH_ALIGN;
                            n_pe    = '0;
                            n_ac    = '0;
                        end
                    end
                    lfc_pkg::PH_ALIGN: begin
                        n_mode = lfc_pkg::MODE_FWD;
                        n_ld   = bal_l;
                        n_rd   = bal_r;
                        if (16'(adiff) < 16'(r_tol)) begin
                            ac_n = (r_ac != 16'hFFFF) ? r_ac + 1'b1 : r_ac;
                        end else begin
                            ac_n = '0;
                        end
                        n_ac = ac_n;
                        if (ac_n >= lfc_pkg::STABLE_TICKS) begin
                            n_phase = lfc_pkg::PH_FOLLOW;
                            n_pe    = '0;
                        end
                    end
                    lfc_pkg::PH_FOLLOW: begin
                        if (ll && !rl) n_side = lfc_pkg::SIDE_LEFT;
                        else if (rl && !ll) n_side = lfc_pkg::SIDE_RIGHT;
                        else if (ll && rl) n_side = lfc_pkg::SIDE_NONE;
                        n_mode = lfc_pkg::MODE_FWD;
                        n_ld   = bal_l;
                        n_rd   = bal_r;
                    end
                    lfc_pkg::PH_EXIT: begin
                        if (pe1 >= r_exit) begin
                            n_phase = lfc_pkg::PH_IDLE;
                            n_pe    = '0;
                            n_ac    = '0;
                            n_side  = lfc_pkg::SIDE_NONE;
                            n_mode  = lfc_pkg::MODE_STOP;
                            n_ld    = '0;
                            n_rd    = '0;
                        end
                    end
                    default: begin
                        n_phase = lfc_pkg::PH_IDLE;
                        n_mode  = lfc_pkg::MODE_STOP;
                        n_ld    = '0;
                        n_rd    = '0;
                    end
                endcase
            end
            lfc_pkg::ACT_CAL_W, lfc_pkg::ACT_CAL_B: begin
                if (r_phase != lfc_pkg::PH_IDLE) begin
                    n_status = lfc_pkg::ST_BUSY;
                end else begin
                    n_emit = 1'b1;
                    if (r_act == lfc_pkg::ACT_CAL_W) begin
                        n_wl[0] = r_l;
                        n_wl[1] = r_r;
                        n_wv    = 1'b1;
                    end else begin
                        n_bl[0] = r_l;
                        n_bl[1] = r_r;
                        n_bv    = 1'b1;
                    end
                    if (n_bv) begin
                        for (int i = 0; i < 2; i++) begin
                            n_thr[i] = (n_bl[i] > pick_margin(n_bl[i], n_wl[i], n_wv))
                                     ? n_bl[i] - pick_margin(n_bl[i], n_wl[i], n_wv)
                                     : n_bl[i];
                            n_at[i]  = pick_target(n_bl[i]);
                        end
                    end
                    n_el = 12'(r_l);
                    n_er = 12'(r_r);
                end
            end
            lfc_pkg::ACT_BEGIN: begin
                if (r_phase != lfc_pkg::PH_IDLE) n_status = lfc_pkg::ST_RUNNING;
                else if (!r_wv) n_status = lfc_pkg::ST_NEED_W;
                else if (!r_bv) n_status = lfc_pkg::ST_NEED_B;
                else begin
                    n_ac    = '0;
                    n_side  = lfc_pkg::SIDE_NONE;
                    n_emit  = 1'b1;
                    n_phase = lfc_pkg::PH_SEARCH;
                    n_pe    = '0;
                    n_mode  = lfc_pkg::MODE_FWD;
                    n_ld    = cmd_speed(lfc_pkg::SEARCH_LEFT, r_lmin);
                    n_rd    = cmd_speed(lfc_pkg::SEARCH_RIGHT, r_rmin);
                end
            end
            lfc_pkg::ACT_DONE: begin
                if (r_phase == lfc_pkg::PH_IDLE) n_status = lfc_pkg::ST_NOT_RUN;
                else if (r_phase == lfc_pkg::PH_EXIT) n_status = lfc_pkg::ST_RUNNING;
                else begin
                    n_phase = lfc_pkg::PH_EXIT;
                    n_pe    = '0;
                    n_mode  = lfc_pkg::MODE_FWD;
                    n_ld    = cmd_speed(r_fbase, r_lmin);
                    n_rd    = cmd_speed(r_fbase, r_rmin);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= S_IDLE;
            r_ov    <= 1'b0;
            r_phase <= lfc_pkg::PH_IDLE;
            r_pe    <= '0;
            r_ac    <= '0;
            r_side  <= lfc_pkg::SIDE_NONE;
            r_wl[0] <= '0;
            r_wl[1] <= '0;
            r_bl[0] <= '0;
            r_bl[1] <= '0;
            r_thr[0] <= '0;
            r_thr[1] <= '0;
            r_at[0] <= '0;
            r_at[1] <= '0;
            r_wv    <= 1'b0;
            r_bv    <= 1'b0;
            r_emit  <= 1'b0;
            r_mode  <= lfc_pkg::MODE_STOP;
            r_ld    <= '0;
            r_rd    <= '0;
        end else begin
            r_seq <= n_seq;
            if (fin_go) begin
                r_ov    <= 1'b1;
                r_phase <= n_phase;
                r_pe    <= n_pe;
                r_ac    <= n_ac;
                r_side  <= n_side;
                r_wl    <= n_wl;
                r_bl    <= n_bl;
                r_thr   <= n_thr;
                r_at    <= n_at;
                r_wv    <= n_wv;
                r_bv    <= n_bv;
                r_emit  <= n_emit;
                r_mode  <= n_mode;
                r_ld    <= n_ld;
                r_rd    <= n_rd;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_seq == S_IDLE && i_in_valid) begin
            r_act  <= i_action;
            r_l    <= i_left_sample;
            r_r    <= i_right_sample;
            r_tick <= i_tick;
        end
        if (fin_go) begin
            r_o_status <= n_status;
            r_o_el     <= n_el;
            r_o_er     <= n_er;
        end
    end

    assign o_in_ready    = (r_seq == S_IDLE);
    assign o_out_valid   = r_ov;
    assign o_status      = r_o_status;
    assign o_phase       = r_phase;
    assign o_drive_mode  = r_mode;
    assign o_left_drive  = r_ld;
    assign o_right_drive = r_rd;
    assign o_emitter_on  = r_emit;
    assign o_calibrated  = r_wv && r_bv;
    assign o_echo_left   = r_o_el;
    assign o_echo_right  = r_o_er;

endmodule

// File: rtl/core/lfc_chk.sv
// ----------------------------------------------------------------------------
// Line-follow controller port checker
// Watches the controller ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ir_line_follow_controller_macros.svh"

module lfc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_status,
    input logic [2:0]  o_phase,
    input logic [1:0]  o_drive_mode,
    input logic [14:0] o_left_drive,
    input logic [14:0] o_right_drive,
    input logic [11:0] o_echo_left,
    input logic [11:0] o_echo_right
);

    `LFC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result word dropped")
    `LFC_ASSERT_NXT(a_one_word, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "second word taken during work")
    `LFC_ASSERT_IMP(a_idle_stop, i_clk, i_rst_n, o_out_valid && o_phase == lfc_pkg::PH_IDLE, o_drive_mode == lfc_pkg::MODE_STOP && o_left_drive == 15'd0 && o_right_drive == 15'd0, "wheels driven in idle")
    `LFC_ASSERT_IMP(a_echo_ok, i_clk, i_rst_n, o_out_valid && (o_echo_left != 12'd0 || o_echo_right != 12'd0), o_status == lfc_pkg::ST_OK, "echo on a failed word")

endmodule

bind ir_line_follow_controller lfc_chk u_lfc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_phase       (o_phase),
    .o_drive_mode  (o_drive_mode),
    .o_left_drive  (o_left_drive),
    .o_right_drive (o_right_drive),
    .o_echo_left   (o_echo_left),
    .o_echo_right  (o_echo_right)
);

// File: test/ir_line_follow_controller_test.sv
// ----------------------------------------------------------------------------
// Line-follow controller testbench
// Drives action words through the valid/ready channel under several APB
// register settings and idle patterns. A table of directed words comes first,
// then random calibrate/begin/service/done runs mixed with noise. Every result
// word is compared field by field with an in-bench model of the phase machine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ir_line_follow_controller_test;

    typedef struct {
        logic [2:0]  status;
        logic [2:0]  phase;
        logic [1:0]  mode;
        logic [14:0] ldrv;
        logic [14:0] rdrv;
        logic        emit;
        logic        cal;
        logic [11:0] echo_l;
        logic [11:0] echo_r;
    } t_ctl_word;

    typedef struct {
        logic [2:0]  act;
        logic [11:0] l;
        logic [11:0] r;
        logic        tick;
        bit          typed;
        logic [2:0]  status;
        logic [2:0]  phase;
    } t_dir_row;

    logic        i_clk = 0, i_rst_n = 0;
    logic        i_in_valid = 0, i_out_ready = 0;
    logic [2:0]  i_action = 0;
    logic [11:0] i_left_sample = 0, i_right_sample = 0;
    logic        i_tick = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic        o_in_ready, o_out_valid, o_emitter_on, o_calibrated, pready;
    logic [2:0]  o_status, o_phase;
    logic [1:0]  o_drive_mode;
    logic [14:0] o_left_drive, o_right_drive;
    logic [11:0] o_echo_left, o_echo_right;
    logic [31:0] prdata;

    ir_line_follow_controller dut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // register copy
    int unsigned lmin, rmin, gain, fbase, abase, sto, exticks, tol;
    // controller state copy
    int unsigned ph, elapsed, acount, lside, emitter, dmode, wvalid, bvalid;
    int unsigned white[2], black[2], thresh[2], target[2], dpair[2];

    t_ctl_word expected_words[$];
    int errors = 0, words_sent = 0, words_checked = 0;
    int idle_mode = 0;

    function automatic void stop_wheels();
        dmode = lfc_pkg::MODE_STOP;
        dpair[0] = 0;
        dpair[1] = 0;
    endfunction

    function automatic void command_speeds(int unsigned l, int unsigned r);
        if (l > lfc_pkg::MAX_DRIVE) l = lfc_pkg::MAX_DRIVE;
        if (r > lfc_pkg::MAX_DRIVE) r = lfc_pkg::MAX_DRIVE;
        if (l > 0 && l < lmin) l = lmin;
        if (r > 0 && r < rmin) r = rmin;
        dmode = lfc_pkg::MODE_FWD;
        dpair[0] = l & 'h7FFF;
        dpair[1] = r & 'h7FFF;
    endfunction

    function automatic bit on_line(int unsigned s, int side);
        return bvalid != 0 && s >= thresh[side];
    endfunction

    function automatic void enter_phase(int unsigned nxt);
        ph = nxt;
        elapsed = 0;
        case (nxt)
            lfc_pkg::PH_IDLE: begin
                acount = 0;
                lside = lfc_pkg::SIDE_NONE;
                stop_wheels();
            end
            lfc_pkg::PH_SEARCH: command_speeds(lfc_pkg::SEARCH_LEFT, lfc_pkg::SEARCH_RIGHT);
            lfc_pkg::PH_PAUSE: stop_wheels();
            lfc_pkg::PH_PIVOT: begin
                dmode = lfc_pkg::MODE_PIVOT;
                dpair[0] = lfc_pkg::PIVOT_DRIVE;
                dpair[1] = lfc_pkg::PIVOT_DRIVE;
            end
            lfc_pkg::PH_ALIGN: acount = 0;
            lfc_pkg::PH_EXIT: command_speeds(fbase, fbase);
            default: ;
        endcase
    endfunction

    function automatic int unsigned margin_for(int unsigned b, int unsigned w);
        int unsigned m, d;
        m = lfc_pkg::MARGIN_MIN;
        if (wvalid == 0) return lfc_pkg::MARGIN_MIN;
        if (b > w) begin
            d = b - w;
            if (d < m) m = (d > 2) ? d - 1 : 1;
            else if (d > lfc_pkg::MARGIN_MAX) m = lfc_pkg::MARGIN_MAX;
        end
        return m;
    endfunction

    function automatic int unsigned target_for(int unsigned b);
        int unsigned off, frac;
        off = lfc_pkg::TARGET_OFFSET;
        if (b == 0) return 0;
        frac = b / 4;
        if (frac == 0) frac = 1;
        if (off > frac) off = frac;
        if (off >= b) off = (b > 1) ? b - 1 : 0;
        return b - off;
    endfunction

    function automatic void balanced_drive(int unsigned base_in, int unsigned l,
                                           int unsigned r, bit bias);
        longint err, sum, delta, lp, rp, base;
        int unsigned tl, tr, dl, dr;
        base = base_in;
        err = longint'(r) - longint'(l);
        sum = longint'(l) + longint'(r);
        tl = target[0] ? target[0] : black[0];
        tr = target[1] ? target[1] : black[1];
        dl = 0;
        dr = 0;
        if (sum == 0) sum = 1;
        if (tl > 0 && l < tl) dl = tl - l;
        if (tr > 0 && r < tr) dr = tr - r;
        if (dl > lfc_pkg::DEFICIT_LIMIT || dr > lfc_pkg::DEFICIT_LIMIT) begin
            if (base > lfc_pkg::DEFICIT_DROP) base -= lfc_pkg::DEFICIT_DROP;
            else base = (lmin > rmin) ? lmin : rmin;
        end
        delta = (err * longint'(gain)) / sum;
        delta += (longint'(dr) - longint'(dl)) * lfc_pkg::DEFICIT_GAIN;
        if (bias && !on_line(l, 0) && !on_line(r, 1)) begin
            if (lside == lfc_pkg::SIDE_LEFT) delta -= lfc_pkg::LOST_BIAS;
            else if (lside == lfc_pkg::SIDE_RIGHT) delta += lfc_pkg::LOST_BIAS;
        end
        lp = base - delta;
        rp = base + delta;
        if (lp < longint'(lmin)) lp = lmin;
        if (rp < longint'(rmin)) rp = rmin;
        if (lp > lfc_pkg::MAX_DRIVE) lp = lfc_pkg::MAX_DRIVE;
        if (rp > lfc_pkg::MAX_DRIVE) rp = lfc_pkg::MAX_DRIVE;
        dmode = lfc_pkg::MODE_FWD;
        dpair[0] = int'(lp) & 'h7FFF;
        dpair[1] = int'(rp) & 'h7FFF;
    endfunction

    function automatic void service_step(int unsigned l, int unsigned r);
        bit ll, rl;
        longint e;
        if (ph != lfc_pkg::PH_IDLE) emitter = 1;
        case (ph)
            lfc_pkg::PH_IDLE: ;
            lfc_pkg::PH_SEARCH: begin
                ll = on_line(l, 0);
                rl = on_line(r, 1);
                if (ll || rl) begin
                    lside = ll ? lfc_pkg::SIDE_LEFT : lfc_pkg::SIDE_RIGHT;
                    enter_phase(lfc_pkg::PH_PAUSE);
                end else if (elapsed > sto) begin
                    enter_phase(lfc_pkg::PH_IDLE);
                end
            end
            lfc_pkg::PH_PAUSE: begin
                stop_wheels();
                if (elapsed >= lfc_pkg::PAUSE_TICKS) enter_phase(lfc_pkg::PH_PIVOT);
            end
            lfc_pkg::PH_PIVOT:
                if (elapsed >= lfc_pkg::PIVOT_TICKS) enter_phase(lfc_pkg::PH_ALIGN);
            lfc_pkg::PH_ALIGN: begin
                e = longint'(r) - longint'(l);
                balanced_drive(abase, l, r, 0);
                if (e < longint'(tol) && e > -longint'(tol)) begin
                    if (acount < 'hFFFF) acount++;
                end else begin
                    acount = 0;
                end
                if (acount >= lfc_pkg::STABLE_TICKS) enter_phase(lfc_pkg::PH_FOLLOW);
            end
            lfc_pkg::PH_FOLLOW: begin
                ll = on_line(l, 0);
                rl = on_line(r, 1);
                if (ll && !rl) lside = lfc_pkg::SIDE_LEFT;
                else if (rl && !ll) lside = lfc_pkg::SIDE_RIGHT;
                else if (ll && rl) lside = lfc_pkg::SIDE_NONE;
                balanced_drive(fbase, l, r, 1);
            end
            lfc_pkg::PH_EXIT: if (elapsed >= exticks) enter_phase(lfc_pkg::PH_IDLE);
            default: begin
                ph = lfc_pkg::PH_IDLE;
                stop_wheels();
            end
        endcase
    endfunction

    function automatic t_ctl_word predict_word(logic [2:0] act, int unsigned l,
                                               int unsigned r, logic tick);
        t_ctl_word w;
        int i;
        w.status = lfc_pkg::ST_OK;
        w.echo_l = 0;
        w.echo_r = 0;
        if (tick && elapsed < 'hFFFF) elapsed++;
        case (act)
            lfc_pkg::ACT_SERVICE: service_step(l, r);
            lfc_pkg::ACT_CAL_W, lfc_pkg::ACT_CAL_B: begin
                if (ph != lfc_pkg::PH_IDLE) begin
                    w.status = lfc_pkg::ST_BUSY;
                end else begin
                    emitter = 1;
                    if (act == lfc_pkg::ACT_CAL_W) begin
                        white[0] = l; white[1] = r; wvalid = 1;
                    end else begin
                        black[0] = l; black[1] = r; bvalid = 1;
                    end
                    if (bvalid) begin
                        for (i = 0; i < 2; i++) begin
                            int unsigned m;
                            m = margin_for(black[i], white[i]);
                            thresh[i] = (black[i] > m) ? black[i] - m : black[i];
                            target[i] = target_for(black[i]);
                        end
                    end
                    w.echo_l = 12'(l);
                    w.echo_r = 12'(r);
                end
            end
            lfc_pkg::ACT_BEGIN: begin
                if (ph != lfc_pkg::PH_IDLE) w.status = lfc_pkg::ST_RUNNING;
                else if (!wvalid) w.status = lfc_pkg::ST_NEED_W;
                else if (!bvalid) w.status = lfc_pkg::ST_NEED_B;
                else begin
                    stop_wheels();
                    acount = 0;
                    lside = lfc_pkg::SIDE_NONE;
                    emitter = 1;
                    enter_phase(lfc_pkg::PH_SEARCH);
                end
            end
            lfc_pkg::ACT_DONE: begin
                if (ph == lfc_pkg::PH_IDLE) w.status = lfc_pkg::ST_NOT_RUN;
                else if (ph == lfc_pkg::PH_EXIT) w.status = lfc_pkg::ST_RUNNING;
                else enter_phase(lfc_pkg::PH_EXIT);
            end
            default: ;
        endcase
        w.phase = 3'(ph);
        w.mode = 2'(dmode);
        w.ldrv = 15'(dpair[0]);
        w.rdrv = 15'(dpair[1]);
        w.emit = 1'(emitter);
        w.cal = wvalid && bvalid;
        return w;
    endfunction

    task automatic write_reg(logic [2:0] idx, int unsigned value);
        @(negedge i_clk);
        psel = 1;
        pwrite = 1;
        penable = 0;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1;
        @(posedge i_clk);
        @(negedge i_clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
        case (idx)
            lfc_pkg::REG_LMIN:  lmin = value & 'h7FFF;
            lfc_pkg::REG_RMIN:  rmin = value & 'h7FFF;
            lfc_pkg::REG_GAIN:  gain = value & 'hFFFF;
            lfc_pkg::REG_FBASE: fbase = value & 'h7FFF;
            lfc_pkg::REG_ABASE: abase = value & 'h7FFF;
            lfc_pkg::REG_STO:   sto = value & 'hFFFF;
            lfc_pkg::REG_EXIT:  exticks = value & 'hFFFF;
            lfc_pkg::REG_TOL:   tol = value & 'hFFF;
            default: ;
        endcase
    endtask

    task automatic set_regs(int unsigned v0, int unsigned v1, int unsigned v2,
                            int unsigned v3, int unsigned v4, int unsigned v5,
                            int unsigned v6, int unsigned v7);
        write_reg(lfc_pkg::REG_LMIN, v0);
        write_reg(lfc_pkg::REG_RMIN, v1);
        write_reg(lfc_pkg::REG_GAIN, v2);
        write_reg(lfc_pkg::REG_FBASE, v3);
        write_reg(lfc_pkg::REG_ABASE, v4);
        write_reg(lfc_pkg::REG_STO, v5);
        write_reg(lfc_pkg::REG_EXIT, v6);
        write_reg(lfc_pkg::REG_TOL, v7);
    endtask

    // returns the predicted word; valid stays high past the accepting edge
    task automatic send_word(logic [2:0] act, logic [11:0] l, logic [11:0] r,
                             logic tick, output t_ctl_word w);
        @(negedge i_clk);
        while ((idle_mode == 1 && $urandom_range(99) < 63) ||
               (idle_mode == 3 && $urandom_range(99) < 18)) begin
            i_in_valid = 0;
            @(negedge i_clk);
        end
        i_action = act;
        i_left_sample = l;
        i_right_sample = r;
        i_tick = tick;
        i_in_valid = 1;
        do @(posedge i_clk); while (!o_in_ready);
        w = predict_word(act, l, r, tick);
        words_sent++;
    endtask

    task automatic push_word(logic [2:0] act, logic [11:0] l, logic [11:0] r,
                             logic tick);
        t_ctl_word w;
        send_word(act, l, r, tick, w);
        expected_words.push_back(w);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic line_samples(int kind, output logic [11:0] l,
                                output logic [11:0] r);
        case (kind)
            0: begin
                l = 12'($urandom_range(0, 700));
                r = 12'($urandom_range(0, 700));
            end
            1: begin
                l = 12'($urandom_range(2000, 4095));
                r = 12'($urandom_range(0, 700));
            end
            2: begin
                l = 12'($urandom_range(0, 700));
                r = 12'($urandom_range(2000, 4095));
            end
            3: begin
                l = 12'($urandom_range(0, 4075));
                r = 12'(l + $urandom_range(0, 20));
            end
            default: begin
                l = 12'($urandom);
                r = 12'($urandom);
            end
        endcase
    endtask

    task automatic run_episode();
        logic [11:0] l, r;
        int n, k, i;
        push_word(lfc_pkg::ACT_CAL_W, 12'($urandom_range(0, 600)),
                  12'($urandom_range(0, 600)), 1'b0);
        if ($urandom_range(9) == 0) begin
            l = 12'(white[0] + $urandom_range(0, 25));
            r = 12'(white[1] + $urandom_range(0, 25));
        end else begin
            l = 12'($urandom_range(1800, 4095));
            r = 12'($urandom_range(1800, 4095));
        end
        push_word(lfc_pkg::ACT_CAL_B, l, r, 1'($urandom_range(1)));
        push_word(lfc_pkg::ACT_BEGIN, 12'($urandom), 12'($urandom), 1'($urandom_range(1)));
        n = $urandom_range(15, 70);
        k = 0;
        for (i = 0; i < n; i++) begin
            if (i % 6 == 0) k = $urandom_range(0, 4);
            line_samples(k, l, r);
            push_word($urandom_range(19) == 0 ? 3'($urandom_range(1, 7)) : lfc_pkg::ACT_SERVICE,
                      l, r, 1'($urandom_range(1)));
        end
        if ($urandom_range(2) == 0) begin
            push_word(lfc_pkg::ACT_DONE, 12'($urandom), 12'($urandom), 1'($urandom_range(1)));
            for (i = 0; i < 8; i++)
                push_word(lfc_pkg::ACT_SERVICE, 12'($urandom), 12'($urandom),
                          1'($urandom_range(1)));
        end
    endtask

    task automatic run_random(int count);
        int target_count, i;
        target_count = words_sent + count;
        while (words_sent < target_count) begin
            if ($urandom_range(9) < 8) begin
                run_episode();
            end else begin
                for (i = 0; i < 5; i++)
                    push_word(3'($urandom), 12'($urandom), 12'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(negedge i_clk) begin
        case (idle_mode)
            2: i_out_ready <= $urandom_range(99) >= 63;
            3: i_out_ready <= $urandom_range(99) >= 18;
            default: i_out_ready <= 1;
        endcase
    end

    always @(posedge i_clk) begin
        t_ctl_word w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                w = expected_words.pop_front();
                check_field("status", w.status, o_status);
                check_field("phase", w.phase, o_phase);
                check_field("drive_mode", w.mode, o_drive_mode);
                check_field("left_drive", w.ldrv, o_left_drive);
                check_field("right_drive", w.rdrv, o_right_drive);
                check_field("emitter_on", w.emit, o_emitter_on);
                check_field("calibrated", w.cal, o_calibrated);
                check_field("echo_left", w.echo_l, o_echo_left);
                check_field("echo_right", w.echo_r, o_echo_right);
                words_checked++;
            end
        end
    end

    t_dir_row dir_rows[] = '{
        '{lfc_pkg::ACT_SERVICE, 12'd0, 12'd0, 1'b0, 1'b1, lfc_pkg::ST_OK, lfc_pkg::PH_IDLE},
        '{lfc_pkg::ACT_BEGIN, 12'd5, 12'd5, 1'b0, 1'b1, lfc_pkg::ST_NEED_W, lfc_pkg::PH_IDLE},
        '{lfc_pkg::ACT_DONE, 12'd0, 12'd0, 1'b1, 1'b1, lfc_pkg::ST_NOT_RUN, lfc_pkg::PH_IDLE},
        '{lfc_pkg::ACT_CAL_W, 12'd0, 12'd4095, 1'b0, 1'b1, lfc_pkg::ST_OK, lfc_pkg::PH_IDLE},
        '{lfc_pkg::ACT_BEGIN, 12'd0, 12'd0, 1'b0, 1'b1, lfc_pkg::ST_NEED_B, lfc_pkg::PH_IDLE},
        '{3'd5, 12'd4095, 12'd0, 1'b1, 1'b1, lfc_pkg::ST_OK, lfc_pkg::PH_IDLE},
        '{3'd6, 12'd1, 12'd2, 1'b0, 1'b1, lfc_pkg::ST_OK, lfc_pkg::PH_IDLE},
        '{3'd7, 12'd4095, 12'd4095, 1'b1, 1'b1, lfc_pkg::ST_OK, lfc_pkg::PH_IDLE},
        '{lfc_pkg::ACT_CAL_B, 12'd3, 12'd2, 1'b0, 1'b1, lfc_pkg::ST_OK, lfc_pkg::PH_IDLE},
        '{lfc_pkg::ACT_CAL_W, 12'd200, 12'd300, 1'b0, 1'b0, lfc_pkg::ST_OK, lfc_pkg::PH_IDLE},
        '{lfc_pkg::ACT_CAL_B, 12'd4095, 12'd3900, 1'b0, 1'b0, lfc_pkg::ST_OK, lfc_pkg::PH_IDLE},
        '{lfc_pkg::ACT_BEGIN, 12'd0, 12'd0, 1'b0, 1'b1, lfc_pkg::ST_OK, lfc_pkg::PH_SEARCH},
        '{lfc_pkg::ACT_CAL_W, 12'd10, 12'd10, 1'b0, 1'b1, lfc_pkg::ST_BUSY, lfc_pkg::PH_SEARCH},
        '{lfc_pkg::ACT_BEGIN, 12'd10, 12'd10, 1'b0, 1'b1, lfc_pkg::ST_RUNNING,
          lfc_pkg::PH_SEARCH},
        '{lfc_pkg::ACT_SERVICE, 12'd100, 12'd100, 1'b1, 1'b0, lfc_pkg::ST_OK, lfc_pkg::PH_IDLE},
        '{lfc_pkg::ACT_SERVICE, 12'd4095, 12'd100, 1'b1, 1'b0, lfc_pkg::ST_OK, lfc_pkg::PH_IDLE},
        '{lfc_pkg::ACT_SERVICE, 12'd0, 12'd0, 1'b1, 1'b0, lfc_pkg::ST_OK, lfc_pkg::PH_IDLE},
        '{lfc_pkg::ACT_SERVICE, 12'd0, 12'd0, 1'b1, 1'b0, lfc_pkg::ST_OK, lfc_pkg::PH_IDLE},
        '{lfc_pkg::ACT_SERVICE, 12'd0, 12'd0, 1'b1, 1'b0, lfc_pkg::ST_OK, lfc_pkg::PH_IDLE},
        '{lfc_pkg::ACT_SERVICE, 12'd4095, 12'd4095, 1'b1, 1'b0, lfc_pkg::ST_OK, lfc_pkg::PH_IDLE},
        '{lfc_pkg::ACT_DONE, 12'd0, 12'd0, 1'b0, 1'b1, lfc_pkg::ST_OK, lfc_pkg::PH_EXIT},
        '{lfc_pkg::ACT_DONE, 12'd0, 12'd0, 1'b0, 1'b1, lfc_pkg::ST_RUNNING, lfc_pkg::PH_EXIT},
        '{lfc_pkg::ACT_CAL_B, 12'd0, 12'd0, 1'b0, 1'b1, lfc_pkg::ST_BUSY, lfc_pkg::PH_EXIT}
    };

    initial begin
        t_ctl_word w;
        lmin = 8000; rmin = 8000; gain = 14000; fbase = 15000;
        abase = 13000; sto = 150; exticks = 15; tol = 25;
        ph = lfc_pkg::PH_IDLE; elapsed = 0; acount = 0; lside = lfc_pkg::SIDE_NONE;
        white = '{0, 0}; black = '{0, 0}; thresh = '{0, 0}; target = '{0, 0};
        wvalid = 0; bvalid = 0; emitter = 0;
        stop_wheels();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].act, dir_rows[i].l, dir_rows[i].r,
                      dir_rows[i].tick, w);
            if (dir_rows[i].typed) begin
                w.status = dir_rows[i].status;
                w.phase = dir_rows[i].phase;
            end
            expected_words.push_back(w);
        end
        drain();

        for (int p = 0; p < 8; p++) begin
            idle_mode = p % 4;
            case (p)
                1: set_regs(0, 0, 65535, 32000, 32000, 1, 1, 4095);
                2: set_regs(32000, 32000, 0, 0, 0, 65535, 65535, 1);
                3: set_regs(8000, 8000, 14000, 15000, 13000, 8, 3, 25);
                4: set_regs(20000, 500, 30000, 3000, 28000, 4, 2, 200);
                5, 6: set_regs($urandom_range(0, 32000), $urandom_range(0, 32000),
                               $urandom, $urandom_range(0, 32000),
                               $urandom_range(0, 32000), $urandom_range(1, 12),
                               $urandom_range(1, 6), $urandom_range(1, 4095));
                7: set_regs(8000, 8000, 14000, 15000, 13000, 150, 15, 25);
                default: ;
            endcase
            run_random(165);
            drain();
        end

        $display("Covered %0d words in 8 register settings and 4 idle patterns;",
                 words_sent);
        $display("%0d result words compared, %0d mismatches.", words_checked, errors);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
